@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the sensor compensation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define ESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define ESC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/esc_pkg.sv @@
// Package of the sensor compensation block: types, constants and helpers.
`timescale 1ns / 1ps
package esc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_TEMP_TRIM       = 3'd0;
  localparam logic [2:0] REG_PRESS_TRIM_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_TRIM_MID  = 3'd2;
  localparam logic [2:0] REG_PRESS_TRIM_HIGH = 3'd3;
  localparam logic [2:0] REG_HUM_TRIM        = 3'd4;

  // Pipeline depth: arithmetic stages, divider stages, tail stages.
  localparam int ARITH_STAGES = 13;
  localparam int DIV_STAGES   = 32;
  localparam int TAIL_STAGES  = 3;
  localparam int LATENCY      = ARITH_STAGES + DIV_STAGES + TAIL_STAGES;

  // Fixed-point constants of the compensation formulas.
  localparam logic [31:0] K_P_OFFSET  = 32'd64000;
  localparam logic [31:0] K_H_OFFSET  = 32'd76800;
  localparam logic [31:0] K_P_FULL    = 32'd1048576;
  localparam logic [31:0] K_P_SCALE   = 32'd3125;
  localparam logic [31:0] K_H_BIAS    = 32'd2097152;
  localparam logic [31:0] K_H_MAX     = 32'd419430400;

  // Values carried through the arithmetic stages.
  typedef struct packed {
    logic [15:0] adc_h;
    logic [19:0] adc_p;
    logic [31:0] ta;
    logic [31:0] d;
    logic [31:0] am;
    logic [31:0] dd;
    logic [31:0] a;
    logic [31:0] bm;
    logic [31:0] tf;
    logic [31:0] temp;
    logic [31:0] pa;
    logic [31:0] q;
    logic [31:0] hv;
    logic [31:0] qq;
    logic [31:0] ap5;
    logic [31:0] ap2;
    logic [31:0] hvh5;
    logic [31:0] vh6;
    logic [31:0] vh3;
    logic [31:0] b1;
    logic [31:0] pm;
    logic [31:0] hl;
    logic [31:0] r1;
    logic [31:0] b;
    logic [31:0] a2;
    logic [31:0] l;
    logic [31:0] r2m;
    logic [31:0] a3m;
    logic [31:0] pn;
    logic [31:0] r;
    logic [31:0] hvv;
    logic [31:0] hq2;
    logic [31:0] hm;
    logic [31:0] num;
    logic [31:0] den;
    logic        big;
    logic [16:0] hum;
  } stage_t;

  // Finished results that ride along with the pressure division.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] tf;
    logic [16:0] hum;
    logic        big;
    logic        zero;
  } carry_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] dq;
    logic [31:0] den;
    carry_t      c;
  } div_t;

  // Arithmetic right shift of a 32-bit two's complement word.
  function automatic logic [31:0] sra32(input logic [31:0] x, input logic [4:0] n);
    sra32 = $unsigned($signed(x) >>> n);
  endfunction

  // One quotient bit of an unsigned restoring division.
  function automatic div_t div_step(input div_t s);
    div_t        o;
    logic [32:0] r;
    logic        qb;
    o  = s;
    r  = {s.rem, s.dq[31]};
    qb = (r >= {1'b0, s.den});
    if (qb) begin
      r = r - {1'b0, s.den};
    end
    o.rem = r[31:0];
    o.dq  = {s.dq[30:0], qb};
    return o;
  endfunction

endpackage

@@ sv/env_sensor_compensation.sv @@
// Top level of the sensor compensation block: trim registers and the pipeline.
// Usage:
//   Raw triples enter on in_valid / in_stall with adc_temp, adc_press and
//   adc_hum. Results leave on out_valid / out_stall as temperature (0.01 degC),
//   pressure (Pa), humidity (1024 per %RH) and fine_temp.
//   Trim words are written through cfg_write, cfg_index and cfg_data while
//   the block is idle; an index above four is ignored.
// Pipeline structure and throughput:
//   Every transaction passes 13 arithmetic stages, a 32-stage
//   restoring divider for the pressure quotient (one quotient bit per stage)
//   and three tail stages. One transaction can enter in every cycle unless in_stall is high.
// Reset:
//   rst clears all valid bits and the trim registers; the pipeline is empty.
// Stall:
//   The whole pipeline advances together. While a result waits with
//   out_stall high, in_stall is high and every stage holds; as long as the
//   output register is empty or taken, a new transaction is accepted.
`timescale 1ns / 1ps
module env_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] adc_temp,
  input  logic [19:0] adc_press,
  input  logic [15:0] adc_hum,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] temperature,
  output logic [31:0] pressure,
  output logic [16:0] humidity,
  output logic [31:0] fine_temp
);

  `include "assert_macros.svh"

  logic [47:0] temp_trim, press_trim_low, press_trim_mid, press_trim_high;
  logic [63:0] hum_trim;
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  logic                       en;
  logic [esc_pkg::LATENCY-1:0] vld;
  esc_pkg::stage_t            st [1:esc_pkg::ARITH_STAGES];
  esc_pkg::stage_t            nx [1:esc_pkg::ARITH_STAGES];
  esc_pkg::div_t              dv [0:esc_pkg::DIV_STAGES-1];
  esc_pkg::div_t              dn [0:esc_pkg::DIV_STAGES-1];
  esc_pkg::div_t              div_init;

  logic [31:0]     ta_p, ta_m1, ta_m2;
  esc_pkg::carry_t ta_c;
  logic [31:0]     tb_p, tb_aa, tb_bb;
  esc_pkg::carry_t tb_c;
  logic [31:0]     p_next, hv_next, press_next;

  // Trim register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim       <= '0;
      press_trim_low  <= '0;
      press_trim_mid  <= '0;
      press_trim_high <= '0;
      hum_trim        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        esc_pkg::REG_TEMP_TRIM:       temp_trim       <= cfg_data[47:0];
        esc_pkg::REG_PRESS_TRIM_LOW:  press_trim_low  <= cfg_data[47:0];
        esc_pkg::REG_PRESS_TRIM_MID:  press_trim_mid  <= cfg_data[47:0];
        esc_pkg::REG_PRESS_TRIM_HIGH: press_trim_high <= cfg_data[47:0];
        esc_pkg::REG_HUM_TRIM:        hum_trim        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Trim word unpacking to 32 bits: t1, p1, h1 and h3 zero-extended, the rest sign-extended.
  assign t1 = {16'b0, temp_trim[15:0]};
  assign t2 = {{16{temp_trim[31]}}, temp_trim[31:16]};
  assign t3 = {{16{temp_trim[47]}}, temp_trim[47:32]};
  assign p1 = {16'b0, press_trim_low[15:0]};
  assign p2 = {{16{press_trim_low[31]}}, press_trim_low[31:16]};
  assign p3 = {{16{press_trim_low[47]}}, press_trim_low[47:32]};
  assign p4 = {{16{press_trim_mid[15]}}, press_trim_mid[15:0]};
  assign p5 = {{16{press_trim_mid[31]}}, press_trim_mid[31:16]};
  assign p6 = {{16{press_trim_mid[47]}}, press_trim_mid[47:32]};
  assign p7 = {{16{press_trim_high[15]}}, press_trim_high[15:0]};
  assign p8 = {{16{press_trim_high[31]}}, press_trim_high[31:16]};
  assign p9 = {{16{press_trim_high[47]}}, press_trim_high[47:32]};
  assign h1 = {24'b0, hum_trim[7:0]};
  assign h2 = {{16{hum_trim[23]}}, hum_trim[23:8]};
  assign h3 = {24'b0, hum_trim[31:24]};
  assign h4 = {{20{hum_trim[43]}}, hum_trim[43:32]};
  assign h5 = {{20{hum_trim[55]}}, hum_trim[55:44]};
  assign h6 = {{24{hum_trim[63]}}, hum_trim[63:56]};

  // The pipeline moves whenever the output register is empty or taken.
  assign out_valid = vld[esc_pkg::LATENCY-1];
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[esc_pkg::LATENCY-2:0], in_valid};
    end
  end

  // Arithmetic stages: at most one multiplier deep per lane and stage.
  always_comb begin
    nx[1]       = '0;
    nx[1].adc_p = adc_press;
    nx[1].adc_h = adc_hum;
    nx[1].ta    = {15'b0, adc_temp[19:3]} - {t1[30:0], 1'b0};
    nx[1].d     = {16'b0, adc_temp[19:4]} - t1;
    for (int k = 2; k <= esc_pkg::ARITH_STAGES; k++) begin
      nx[k] = st[k-1];
    end
    // Temperature products.
    nx[2].am = st[1].ta * t2;
    nx[2].dd = st[1].d * st[1].d;
    nx[3].a  = esc_pkg::sra32(st[2].am, 5'd11);
    nx[3].bm = esc_pkg::sra32(st[2].dd, 5'd12) * t3;
    nx[4].tf = st[3].a + esc_pkg::sra32(st[3].bm, 5'd14);
    // Temperature result and the offsets for pressure and humidity.
    nx[5].temp = esc_pkg::sra32(st[4].tf * 32'd5 + 32'd128, 5'd8);
    nx[5].pa   = esc_pkg::sra32(st[4].tf, 5'd1) - esc_pkg::K_P_OFFSET;
    nx[5].q    = esc_pkg::sra32(esc_pkg::sra32(st[4].tf, 5'd1) - esc_pkg::K_P_OFFSET, 5'd2);
    nx[5].hv   = st[4].tf - esc_pkg::K_H_OFFSET;
    // First products of pressure and humidity.
    nx[6].qq   = st[5].q * st[5].q;
    nx[6].ap5  = st[5].pa * p5;
    nx[6].ap2  = p2 * st[5].pa;
    nx[6].hvh5 = h5 * st[5].hv;
    nx[6].vh6  = st[5].hv * h6;
    nx[6].vh3  = st[5].hv * h3;
    // Second products.
    nx[7].b1 = esc_pkg::sra32(st[6].qq, 5'd11) * p6;
    nx[7].pm = p3 * esc_pkg::sra32(st[6].qq, 5'd13);
    nx[7].hl = {2'b0, st[6].adc_h, 14'b0} - {h4[11:0], 20'b0} - st[6].hvh5 + 32'd16384;
    nx[7].r1 = esc_pkg::sra32(st[6].vh6, 5'd10)
             * (esc_pkg::sra32(st[6].vh3, 5'd11) + 32'd32768);
    // Pressure offset and scale terms, humidity left factor.
    nx[8].b   = esc_pkg::sra32(st[7].b1 + {st[7].ap5[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'b0};
    nx[8].a2  = esc_pkg::sra32(esc_pkg::sra32(st[7].pm, 5'd3)
                + esc_pkg::sra32(st[7].ap2, 5'd1), 5'd18);
    nx[8].l   = esc_pkg::sra32(st[7].hl, 5'd15);
    nx[8].r2m = (esc_pkg::sra32(st[7].r1, 5'd10) + esc_pkg::K_H_BIAS) * h2;
    // Divisor product, dividend and humidity right factor.
    nx[9].a3m = (32'd32768 + st[8].a2) * p1;
    nx[9].pn  = ((esc_pkg::K_P_FULL - {12'b0, st[8].adc_p}) - esc_pkg::sra32(st[8].b, 5'd12))
              * esc_pkg::K_P_SCALE;
    nx[9].r   = esc_pkg::sra32(st[8].r2m + 32'd8192, 5'd14);
    // Division operands; humidity product.
    nx[10].big = st[9].pn[31];
    nx[10].num = st[9].pn[31] ? st[9].pn : {st[9].pn[30:0], 1'b0};
    nx[10].den = esc_pkg::sra32(st[9].a3m, 5'd15);
    nx[10].hvv = st[9].l * st[9].r;
    // Humidity correction terms.
    nx[11].hq2 = esc_pkg::sra32(st[10].hvv, 5'd15) * esc_pkg::sra32(st[10].hvv, 5'd15);
    nx[12].hm  = esc_pkg::sra32(st[11].hq2, 5'd7) * h1;
    // Humidity clamp to 0..100 %RH.
    hv_next = st[12].hvv - esc_pkg::sra32(st[12].hm, 5'd4);
    if (hv_next[31]) begin
      nx[13].hum = '0;
    end else if (hv_next > esc_pkg::K_H_MAX) begin
      nx[13].hum = esc_pkg::K_H_MAX[28:12];
    end else begin
      nx[13].hum = hv_next[28:12];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= esc_pkg::ARITH_STAGES; k++) begin
        st[k] <= nx[k];
      end
    end
  end

  // Pressure divider, one quotient bit per stage.
  always_comb begin
    div_init        = '0;
    div_init.dq     = st[esc_pkg::ARITH_STAGES].num;
    div_init.den    = st[esc_pkg::ARITH_STAGES].den;
    div_init.c.temp = st[esc_pkg::ARITH_STAGES].temp;
    div_init.c.tf   = st[esc_pkg::ARITH_STAGES].tf;
    div_init.c.hum  = st[esc_pkg::ARITH_STAGES].hum;
    div_init.c.big  = st[esc_pkg::ARITH_STAGES].big;
    div_init.c.zero = (st[esc_pkg::ARITH_STAGES].den == '0);
    dn[0] = esc_pkg::div_step(div_init);
    for (int k = 1; k < esc_pkg::DIV_STAGES; k++) begin
      dn[k] = esc_pkg::div_step(dv[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < esc_pkg::DIV_STAGES; k++) begin
        dv[k] <= dn[k];
      end
    end
  end

  // Tail: quotient doubling for a large dividend, second-order pressure terms and final sum (zero for a zero divisor).
  assign p_next = dv[esc_pkg::DIV_STAGES-1].c.big ? {dv[esc_pkg::DIV_STAGES-1].dq[30:0], 1'b0}
                                                  : dv[esc_pkg::DIV_STAGES-1].dq;
  assign press_next = tb_c.zero ? '0
                    : tb_p + esc_pkg::sra32(esc_pkg::sra32(tb_aa, 5'd12) + tb_bb + p7, 5'd4);

  always_ff @(posedge clk) begin
    if (en) begin
      ta_p        <= p_next;
      ta_m1       <= {3'b0, p_next[31:3]} * {3'b0, p_next[31:3]};
      ta_m2       <= {2'b0, p_next[31:2]} * p8;
      ta_c        <= dv[esc_pkg::DIV_STAGES-1].c;
      tb_p        <= ta_p;
      tb_aa       <= p9 * {13'b0, ta_m1[31:13]};
      tb_bb       <= esc_pkg::sra32(ta_m2, 5'd13);
      tb_c        <= ta_c;
      temperature <= tb_c.temp;
      fine_temp   <= tb_c.tf;
      humidity    <= tb_c.hum;
      pressure    <= press_next;
    end
  end

  // Checks on the pipeline control, the humidity range and the zero-divisor pressure.
  `ESC_ASSERT(a_stall_only_when_full, in_stall |-> (out_valid && out_stall), "stall without a waiting result")
  `ESC_ASSERT(a_hum_range, out_valid |-> (humidity <= 17'd102400), "humidity above full scale")
  `ESC_ASSERT_NEXT(a_zero_div, (en && vld[esc_pkg::LATENCY-2] && tb_c.zero), (pressure == 32'd0), "pressure not zero for zero divisor")

endmodule

@@ tb/sv/tb.sv @@
// Testbench of the sensor compensation block: directed and random checks.
`timescale 1ns / 1ps
module tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [19:0] adc_temp;
  logic [19:0] adc_press;
  logic [15:0] adc_hum;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] temperature;
  logic [31:0] pressure;
  logic [16:0] humidity;
  logic [31:0] fine_temp;

  // One compensated reading as the block should return it.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
    logic [31:0] tf;
  } reading_t;

  reading_t    pending_readings[$];
  logic [63:0] trim_regs[5];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_cycles;
  int          mismatches;
  int          readings_checked;
  int          items_sent;
  int          cycle_count;

  env_sensor_compensation u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .adc_temp(adc_temp), .adc_press(adc_press), .adc_hum(adc_hum),
    .out_valid(out_valid), .out_stall(out_stall), .temperature(temperature),
    .pressure(pressure), .humidity(humidity), .fine_temp(fine_temp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Arithmetic shift right on a 32-bit word.
  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Integer compensation of one raw triple with the current trim words.
  function automatic reading_t compensate(input logic [19:0] at, input logic [19:0] ap,
                                          input logic [15:0] ah);
    reading_t    r;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, d, tf, q, p, v, l, rr;
    t1 = {16'd0, trim_regs[0][15:0]};
    t2 = sx16(trim_regs[0][31:16]);
    t3 = sx16(trim_regs[0][47:32]);
    p1 = {16'd0, trim_regs[1][15:0]};
    p2 = sx16(trim_regs[1][31:16]);
    p3 = sx16(trim_regs[1][47:32]);
    p4 = sx16(trim_regs[2][15:0]);
    p5 = sx16(trim_regs[2][31:16]);
    p6 = sx16(trim_regs[2][47:32]);
    p7 = sx16(trim_regs[3][15:0]);
    p8 = sx16(trim_regs[3][31:16]);
    p9 = sx16(trim_regs[3][47:32]);
    h1 = {24'd0, trim_regs[4][7:0]};
    h2 = sx16(trim_regs[4][23:8]);
    h3 = {24'd0, trim_regs[4][31:24]};
    h4 = {{20{trim_regs[4][43]}}, trim_regs[4][43:32]};
    h5 = {{20{trim_regs[4][55]}}, trim_regs[4][55:44]};
    h6 = {{24{trim_regs[4][63]}}, trim_regs[4][63:56]};
    // Temperature and the fine term.
    a  = asr(((32'(at) >> 3) - (t1 << 1)) * t2, 11);
    d  = (32'(at) >> 4) - t1;
    b  = asr(asr(d * d, 12) * t3, 14);
    tf = a + b;
    r.tf   = tf;
    r.temp = asr(tf * 32'd5 + 32'd128, 8);
    // Pressure, with the zero divisor giving zero.
    a = asr(tf, 1) - 32'd64000;
    q = asr(a, 2);
    b = asr(q * q, 11) * p6;
    b = b + ((a * p5) << 1);
    b = asr(b, 2) + (p4 << 16);
    a = asr(asr(p3 * asr(q * q, 13), 3) + asr(p2 * a, 1), 18);
    a = asr((32'd32768 + a) * p1, 15);
    if (a == 32'd0) begin
      r.press = 32'd0;
    end else begin
      p = ((32'd1048576 - 32'(ap)) - asr(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      a = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = asr((p >> 2) * p8, 13);
      r.press = p + asr(a + b + p7, 4);
    end
    // Humidity, clamped to the full scale.
    v  = tf - 32'd76800;
    l  = asr((32'(ah) << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
    rr = asr(v * h6, 10) * (asr(v * h3, 11) + 32'd32768);
    rr = (asr(rr, 10) + 32'd2097152) * h2 + 32'd8192;
    rr = asr(rr, 14);
    v  = l * rr;
    q  = asr(v, 15);
    v  = v - asr(asr(q * q, 7) * h1, 4);
    if (v[31]) v = 32'd0;
    else if (v > 32'd419430400) v = 32'd419430400;
    r.hum = 17'(v >> 12);
    return r;
  endfunction

  // Write one trim register at a falling edge; the block must be idle.
  task automatic write_trim(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx <= esc_pkg::REG_HUM_TRIM) begin
      trim_regs[idx] = (idx == esc_pkg::REG_HUM_TRIM) ? val : {16'd0, val[47:0]};
    end
  endtask

  // Offer one triple and hold it until the block takes the transaction.
  // Valid stays high until the next offer or idle cycle replaces it.
  task automatic send_triple(input logic [19:0] at, input logic [19:0] ap,
                             input logic [15:0] ah);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    adc_temp  <= at;
    adc_press <= ap;
    adc_hum   <= ah;
    pending_readings.push_back(compensate(at, ap, ah));
    items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and let the pipeline empty before a register write.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (esc_pkg::LATENCY + 4) @(negedge clk);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_triple(20'($urandom), 20'($urandom), 16'($urandom));
    end
  endtask

  // Receiver stall: random idling, or a long counted hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted reading with the oldest expectation.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected reading t=%0d", $signed(temperature));
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (want.temp !== temperature || want.press !== pressure ||
            want.hum !== humidity || want.tf !== fine_temp) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp t=%0d p=%0d h=%0d tf=%0d got t=%0d p=%0d h=%0d tf=%0d",
                     $signed(want.temp), want.press, want.hum, $signed(want.tf),
                     $signed(temperature), pressure, humidity, $signed(fine_temp));
        end
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Zero trims: the pressure divisor is zero everywhere.
  task automatic test_zero_trim;
    send_triple(20'd0, 20'd0, 16'd0);
    send_triple(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    drain();
  endtask

  // Typical trims, an ignored write to index 7, and the extremes of each raw field.
  task automatic test_typical_trim;
    write_trim(esc_pkg::REG_TEMP_TRIM, {16'd0, 16'd50, 16'd26435, 16'd27504});
    write_trim(esc_pkg::REG_PRESS_TRIM_LOW, {16'd0, 16'hD0D0, 16'hD66C, 16'd36477});
    write_trim(esc_pkg::REG_PRESS_TRIM_MID, {16'd0, 16'hFFF9, 16'h0080, 16'd2855});
    write_trim(esc_pkg::REG_PRESS_TRIM_HIGH, {16'd0, 16'd6000, 16'hEC00, 16'd15500});
    write_trim(esc_pkg::REG_HUM_TRIM, {8'd30, 12'd50, 12'd339, 8'd0, 16'd362, 8'd75});
    write_trim(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send_triple(20'd519888, 20'd415148, 16'd30000);
    send_triple(20'd0, 20'd0, 16'd0);
    send_triple(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_triple(20'hFFFFF, 20'd0, 16'd0);
    send_triple(20'd0, 20'hFFFFF, 16'hFFFF);
    send_triple(20'h55555, 20'hAAAAA, 16'h5555);
    send_triple(20'hAAAAA, 20'h55555, 16'hAAAA);
    send_triple(20'd519888, 20'd415148, 16'hFFFF);
    drain();
  endtask

  // Extreme trims, all ones and then the sign bits alone, each with random triples.
  task automatic test_extreme_trim;
    for (int i = 0; i < 5; i++) write_trim(3'(i), 64'hFFFF_FFFF_FFFF_FFFF);
    send_random(8);
    drain();
    for (int i = 0; i < 4; i++) write_trim(3'(i), 64'h8000_8000_8000);
    write_trim(esc_pkg::REG_HUM_TRIM, 64'h8080_0800_8080_0080);
    send_random(8);
    drain();
  endtask

  // Random triples under one idling mix, with fresh random trims.
  task automatic test_random_phase(input int s_pct, input int r_pct, input int n);
    for (int i = 0; i < 5; i++) write_trim(3'(i), {$urandom, $urandom});
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    send_random(n);
    drain();
  endtask

  // Long receiver hold-off while triples keep arriving.
  task automatic test_back_pressure;
    send_idle_pct = 0;
    hold_off_cycles = 200;
    send_random(120);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    adc_temp = '0;
    adc_press = '0;
    adc_hum = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 0;
    mismatches = 0;
    readings_checked = 0;
    items_sent = 0;
    cycle_count = 0;
    for (int i = 0; i < 5; i++) trim_regs[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_zero_trim();
    test_typical_trim();
    test_extreme_trim();
    test_random_phase(23, 73, 230);
    test_random_phase(73, 23, 230);
    test_random_phase(0, 0, 230);
    test_back_pressure();
    $display("Sent %0d raw triples over several trim sets; %0d readings checked.",
             items_sent, readings_checked);
    $display("Covered zero divisor, field extremes, back-pressure and %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
